FILE: hdl/dec_pkg.sv
// Shared constants and types for the diagonal edge crossing checker.
package dec_pkg;

  // Widths of the channel fields and the default coordinate width.
  localparam int FIELD_W         = 32;
  localparam int COORD_WIDTH_DEF = 32;

  // Colinear tolerance register.
  localparam int              TOL_W     = 40;
  localparam logic [TOL_W-1:0] TOL_RESET = 40'd4295;

  // Configuration port: one 40-bit register, so 64-bit data and 8-byte stride.
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;
  localparam logic REG_COLINEAR_TOL = 1'b0;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  // Per-edge control carried with the coordinates through the queue.
  typedef struct packed {
    logic edge_ok;  // a previous vertex exists, so this beat closes an edge
    logic first;    // start of a chain: clear the crossed flag
    logic last;     // end of a chain: emit the verdict
  } edge_flags_t;

  localparam int FLAGS_W = $bits(edge_flags_t);

endpackage

FILE: hdl/dec_in_if.sv
// Input channel: one polygon vertex with the diagonal and chain markers.
interface dec_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [dec_pkg::FIELD_W-1:0] diag_start_x;
  logic signed [dec_pkg::FIELD_W-1:0] diag_start_y;
  logic signed [dec_pkg::FIELD_W-1:0] diag_end_x;
  logic signed [dec_pkg::FIELD_W-1:0] diag_end_y;
  logic signed [dec_pkg::FIELD_W-1:0] vertex_x;
  logic signed [dec_pkg::FIELD_W-1:0] vertex_y;
  logic                               first_vertex;
  logic                               last_vertex;

  modport source (
    output valid, diag_start_x, diag_start_y, diag_end_x, diag_end_y,
           vertex_x, vertex_y, first_vertex, last_vertex,
    input  ready
  );
  modport sink (
    input  valid, diag_start_x, diag_start_y, diag_end_x, diag_end_y,
           vertex_x, vertex_y, first_vertex, last_vertex,
    output ready
  );
endinterface

FILE: hdl/dec_out_if.sv
// Result channel: the verdict for one polygon chain.
interface dec_out_if;
  logic valid;
  logic ready;
  logic is_diagonal;

  modport source (output valid, is_diagonal, input ready);
  modport sink   (input valid, is_diagonal, output ready);
endinterface

FILE: hdl/diagonal_edge_crossing_check.sv
// Top level of the diagonal edge crossing checker.
//
// Usage: stream the vertices of an open polygon chain on in_ch, one beat per
// vertex, each beat also carrying the candidate diagonal. first_vertex opens a
// chain, last_vertex closes it; each consecutive vertex pair is an edge and the
// closing edge back to the first vertex is not tested. After the last vertex
// one beat appears on out_ch: is_diagonal is 1 when no edge properly crossed
// the diagonal. Chains without a last vertex produce no result.
// The tolerance for collinear cross products is register 0 of the APB-style
// port (byte address 0, 40 bits, reset 4295); write it only while idle.
//
// Throughput: one vertex per cycle while out_ch is ready; the front takes a
// beat whenever its four-entry queue has room.
// Path: after the last vertex is accepted, its verdict passes the queue, the
// difference, product and sign stages and then the output register before it
// shows on out_ch, later if the queue already holds beats.
// Stall: when out_ch holds a result that is not taken, the back pipeline holds
// and the queue fills; in_ch.ready drops only once the queue is full.
// Reset: rst_n clears the pipeline, the queue, the chain state and restores
// the tolerance; no beat is pending afterwards.
module diagonal_edge_crossing_check #(
  parameter int COORD_WIDTH = dec_pkg::COORD_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  dec_in_if.sink                         in_ch,
  dec_out_if.source                      out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [dec_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [dec_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [dec_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  localparam int CRD_W = 8 * COORD_WIDTH;
  localparam int Q_W   = CRD_W + dec_pkg::FLAGS_W;

  logic                      push;
  logic [CRD_W-1:0]          push_coords;
  dec_pkg::edge_flags_t      push_flags;
  logic                      pop;
  logic                      q_full;
  logic                      q_empty;
  logic [Q_W-1:0]            q_head;
  logic [dec_pkg::TOL_W-1:0] tol;

  // Tolerance register.
  dec_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .tol         (tol)
  );

  // Front: accept vertex beats and form one edge record each.
  dec_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .q_full      (q_full),
    .push        (push),
    .push_coords (push_coords),
    .push_flags  (push_flags)
  );

  // Queue: decouple acceptance from the back-end stall.
  dec_queue #(.WIDTH(Q_W), .DEPTH(dec_pkg::QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_flags, push_coords}),
    .pop       (pop),
    .head_data (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back: orientation tests, chain verdict and result register.
  dec_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_coords (q_head[CRD_W-1:0]),
    .q_flags  (dec_pkg::edge_flags_t'(q_head[Q_W-1:CRD_W])),
    .pop      (pop),
    .tol      (tol),
    .out_ch   (out_ch)
  );

endmodule

FILE: hdl/dec_cfg.sv
// APB-style register block holding the colinear tolerance.
module dec_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [dec_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [dec_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [dec_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready,
  output logic [dec_pkg::TOL_W-1:0]         tol
);

  logic [dec_pkg::TOL_W-1:0] tol_r, tol_nxt;
  logic                      sel_tol;
  logic                      wr_en;

  assign cfg_pready = 1'b1;
  // Register index sits above the 8-byte offset.
  assign sel_tol    = (cfg_paddr[dec_pkg::CFG_ADDR_W-1] == dec_pkg::REG_COLINEAR_TOL);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    tol_nxt = tol_r;
    if (wr_en && sel_tol) begin
      tol_nxt = cfg_pwdata[dec_pkg::TOL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= dec_pkg::TOL_RESET;
    end else begin
      tol_r <= tol_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (sel_tol) begin
      cfg_prdata = {{(dec_pkg::CFG_DATA_W-dec_pkg::TOL_W){1'b0}}, tol_r};
    end
  end

  assign tol = tol_r;

endmodule

FILE: hdl/dec_front.sv
// Front end: accept vertex beats, pair each with the previous vertex, classify.
module dec_front #(
  parameter int COORD_WIDTH = dec_pkg::COORD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  dec_in_if.sink                   in_ch,
  input  logic                     q_full,
  output logic                     push,
  output logic [8*COORD_WIDTH-1:0] push_coords,
  output dec_pkg::edge_flags_t     push_flags
);

  localparam int CW = COORD_WIDTH;

  logic [CW-1:0] prev_x_r, prev_x_nxt;
  logic [CW-1:0] prev_y_r, prev_y_nxt;
  logic          have_prev_r, have_prev_nxt;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && in_ch.ready;

  // Keep only the low coordinate bits; the back sign-extends them.
  assign push_coords = {in_ch.diag_start_x[CW-1:0], in_ch.diag_start_y[CW-1:0],
                        in_ch.diag_end_x[CW-1:0],   in_ch.diag_end_y[CW-1:0],
                        prev_x_r,                   prev_y_r,
                        in_ch.vertex_x[CW-1:0],     in_ch.vertex_y[CW-1:0]};

  assign push_flags.edge_ok = have_prev_r && !in_ch.first_vertex;
  assign push_flags.first   = in_ch.first_vertex;
  assign push_flags.last    = in_ch.last_vertex;

  always_comb begin
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    have_prev_nxt = have_prev_r;
    if (push) begin
      prev_x_nxt    = in_ch.vertex_x[CW-1:0];
      prev_y_nxt    = in_ch.vertex_y[CW-1:0];
      have_prev_nxt = !in_ch.last_vertex;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      have_prev_r <= 1'b0;
    end else begin
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      have_prev_r <= have_prev_nxt;
    end
  end

endmodule

FILE: hdl/dec_queue.sv
// Short FIFO between the front and the back.
module dec_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = dec_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW:0]      wr_ptr_r, wr_ptr_nxt;
  logic [AW:0]      rd_ptr_r, rd_ptr_nxt;
  logic             do_push;
  logic             do_pop;

  assign empty     = (wr_ptr_r == rd_ptr_r);
  assign full      = (wr_ptr_r[AW] != rd_ptr_r[AW]) && (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_data = mem_r[rd_ptr_r[AW-1:0]];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r[AW-1:0]] <= push_data;
    end
  end

endmodule

FILE: hdl/dec_back.sv
// Back end: orientation pipeline, crossing flag and result register.
module dec_back #(
  parameter int COORD_WIDTH = dec_pkg::COORD_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  logic [8*COORD_WIDTH-1:0]  q_coords,
  input  dec_pkg::edge_flags_t      q_flags,
  output logic                      pop,
  input  logic [dec_pkg::TOL_W-1:0] tol,
  dec_out_if.source                 out_ch
);

  localparam int CW    = COORD_WIDTH;
  localparam int DW    = CW + 1;
  localparam int PW    = 2 * DW;
  localparam int XW    = PW + 1;
  localparam int CMP_W = (XW > dec_pkg::TOL_W + 1) ? XW : dec_pkg::TOL_W + 1;

  // Coordinates at the queue head, sign-extended by one bit.
  logic signed [DW-1:0] sx, sy, ex, ey, ux, uy, vx, vy;
  // Per orientation: points a, b, c of orient(a, b, c).
  logic signed [DW-1:0] ax [4], ay [4], bx [4], by [4], cx [4], cy [4];

  // Stage A: coordinate differences.
  logic                 a_v_r, a_v_nxt;
  dec_pkg::edge_flags_t a_f_r;
  logic signed [DW-1:0] ma_r [4], mb_r [4], na_r [4], nb_r [4];
  // Stage B: products.
  logic                 b_v_r, b_v_nxt;
  dec_pkg::edge_flags_t b_f_r;
  logic signed [PW-1:0] pa_r [4], pb_r [4];
  // Stage C: orientation signs.
  logic                 c_v_r, c_v_nxt;
  dec_pkg::edge_flags_t c_f_r;
  logic [3:0]           pos_r, neg_r, pos_nxt, neg_nxt;

  logic signed [XW-1:0]    xprod   [4];
  logic signed [CMP_W-1:0] cross_e [4];
  logic signed [CMP_W-1:0] tol_pos, tol_neg;

  logic adv;
  logic hit;
  logic crossed_upd;
  logic crossed_r, crossed_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_diag_r, out_diag_nxt;

  function automatic logic signed [DW-1:0] sext(input logic [CW-1:0] v);
    return {v[CW-1], v};
  endfunction

  assign sx = sext(q_coords[7*CW +: CW]);
  assign sy = sext(q_coords[6*CW +: CW]);
  assign ex = sext(q_coords[5*CW +: CW]);
  assign ey = sext(q_coords[4*CW +: CW]);
  assign ux = sext(q_coords[3*CW +: CW]);
  assign uy = sext(q_coords[2*CW +: CW]);
  assign vx = sext(q_coords[1*CW +: CW]);
  assign vy = sext(q_coords[0*CW +: CW]);

  always_comb begin
    ax[0] = sx; ay[0] = sy; bx[0] = ex; by[0] = ey; cx[0] = ux; cy[0] = uy;
    ax[1] = sx; ay[1] = sy; bx[1] = ex; by[1] = ey; cx[1] = vx; cy[1] = vy;
    ax[2] = ux; ay[2] = uy; bx[2] = vx; by[2] = vy; cx[2] = sx; cy[2] = sy;
    ax[3] = ux; ay[3] = uy; bx[3] = vx; by[3] = vy; cx[3] = ex; cy[3] = ey;
  end

  // The whole pipeline moves together whenever the result register can take a beat.
  assign adv = !out_valid_r || out_ch.ready;
  assign pop = adv && !q_empty;

  assign a_v_nxt = adv ? !q_empty : a_v_r;
  assign b_v_nxt = adv ? a_v_r    : b_v_r;
  assign c_v_nxt = adv ? b_v_r    : c_v_r;

  // Stage A: differences fit in one extra bit.
  always_ff @(posedge clk) begin
    if (adv) begin
      a_f_r <= q_flags;
      for (int k = 0; k < 4; k++) begin
        ma_r[k] <= by[k] - ay[k];
        mb_r[k] <= cx[k] - bx[k];
        na_r[k] <= bx[k] - ax[k];
        nb_r[k] <= cy[k] - by[k];
      end
    end
  end

  // Stage B: full-width products.
  always_ff @(posedge clk) begin
    if (adv) begin
      b_f_r <= a_f_r;
      for (int k = 0; k < 4; k++) begin
        pa_r[k] <= ma_r[k] * mb_r[k];
        pb_r[k] <= na_r[k] * nb_r[k];
      end
    end
  end

  // Stage C: cross product against plus and minus the tolerance.
  assign tol_pos = signed'({{(CMP_W-dec_pkg::TOL_W){1'b0}}, tol});
  assign tol_neg = -tol_pos;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      xprod[k]   = XW'(pa_r[k]) - XW'(pb_r[k]);
      cross_e[k] = CMP_W'(xprod[k]);
      pos_nxt[k] = cross_e[k] > tol_pos;
      neg_nxt[k] = cross_e[k] < tol_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_f_r <= b_f_r;
      pos_r <= pos_nxt;
      neg_r <= neg_nxt;
    end
  end

  // Proper crossing: no collinear sign, and both sign pairs differ.
  assign hit = (&(pos_r | neg_r)) && (pos_r[0] != pos_r[1]) && (pos_r[2] != pos_r[3]);
  assign crossed_upd = (c_f_r.first ? 1'b0 : crossed_r) || (c_f_r.edge_ok && hit);

  always_comb begin
    crossed_nxt   = crossed_r;
    out_valid_nxt = out_valid_r;
    out_diag_nxt  = out_diag_r;
    if (adv) begin
      out_valid_nxt = 1'b0;
      if (c_v_r) begin
        crossed_nxt = c_f_r.last ? 1'b0 : crossed_upd;
        if (c_f_r.last) begin
          out_valid_nxt = 1'b1;
          out_diag_nxt  = !crossed_upd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      crossed_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_v_r       <= a_v_nxt;
      b_v_r       <= b_v_nxt;
      c_v_r       <= c_v_nxt;
      crossed_r   <= crossed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_diag_r <= out_diag_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.is_diagonal = out_diag_r;

endmodule

FILE: test/diagonal_edge_crossing_check_test.sv
// Self-checking testbench for the diagonal edge crossing checker.
module diagonal_edge_crossing_check_test;

  // Package widths used in casts and declarations below.
  localparam int FIELD_W    = dec_pkg::FIELD_W;
  localparam int TOL_W      = dec_pkg::TOL_W;
  localparam int CFG_DATA_W = dec_pkg::CFG_DATA_W;
  localparam int CFG_ADDR_W = dec_pkg::CFG_ADDR_W;

  // Q15.16 unit, coordinate extremes and the width that holds a cross product exactly.
  localparam int UNIT    = 65536;
  localparam int C_MIN   = 32'h8000_0000;
  localparam int C_MAX   = 32'h7fff_ffff;
  localparam int COORD_W = dec_pkg::COORD_WIDTH_DEF;
  localparam int CROSS_W = 2 * FIELD_W + 7;

  // Drain allowance covers the queue plus the four pipeline stages, with margin.
  localparam int DRAIN_CYCLES = 4 * (dec_pkg::QUEUE_DEPTH + 4);
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int SEG_BEATS    = 215;

  localparam logic [CFG_ADDR_W-1:0] TOL_ADDR = {dec_pkg::REG_COLINEAR_TOL, 3'b000};

  typedef logic signed [CROSS_W-1:0] cross_t;

  typedef enum logic [1:0] {SIDE_ON, SIDE_POS, SIDE_NEG} side_t;
  typedef enum logic {CHK_MODEL, CHK_TABLE} verdict_src_t;
  typedef enum logic [1:0] {SPAN_FULL, SPAN_UNITS, SPAN_LSB, SPAN_EDGES} coord_mode_t;

  typedef struct packed {
    logic [FIELD_W-1:0] sx;
    logic [FIELD_W-1:0] sy;
    logic [FIELD_W-1:0] ex;
    logic [FIELD_W-1:0] ey;
    logic [FIELD_W-1:0] vx;
    logic [FIELD_W-1:0] vy;
    logic               first;
    logic               last;
  } vertex_beat_t;

  typedef struct {
    vertex_beat_t beat;
    verdict_src_t src;
    logic         verdict;
  } directed_row_t;

  logic clk;
  logic rst_n;

  dec_in_if  vtx_ch();
  dec_out_if verdict_ch();

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  diagonal_edge_crossing_check #(
    .COORD_WIDTH(COORD_W)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (vtx_ch),
    .out_ch     (verdict_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Shadow of the chain state and of the tolerance register.
  logic [TOL_W-1:0] tol_shadow    = dec_pkg::TOL_RESET;
  cross_t           chain_px      = '0;
  cross_t           chain_py      = '0;
  logic             chain_open    = 1'b0;
  logic             chain_crossed = 1'b0;

  // Verdicts still owed by the block, oldest first.
  logic verdict_q[$];

  // Typed verdict that travels with the beat on the bus, for table rows.
  logic row_typed;
  logic row_verdict;

  int mismatch_count = 0;
  int beats_sent     = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_asked     = 0;
  int hold_served    = 0;
  int hold_left      = 0;

  directed_row_t directed_rows[$];

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Keep the low COORD_W bits and sign-extend them to the product width.
  function automatic cross_t widen(logic [FIELD_W-1:0] v);
    cross_t w;
    w = '0;
    w[COORD_W-1:0] = v[COORD_W-1:0];
    return (w <<< (CROSS_W - COORD_W)) >>> (CROSS_W - COORD_W);
  endfunction

  // Side of c relative to the line a->b; inside the tolerance band it is on the line.
  function automatic side_t side_of(cross_t ax, cross_t ay, cross_t bx, cross_t by,
                                    cross_t cx, cross_t cy);
    cross_t c;
    cross_t lim;
    c = (by - ay) * (cx - bx) - (bx - ax) * (cy - by);
    lim = '0;
    lim[TOL_W-1:0] = tol_shadow;
    if (c > lim) return SIDE_POS;
    if (c < -lim) return SIDE_NEG;
    return SIDE_ON;
  endfunction

  // Proper crossing of diagonal s->e with edge u->v; any collinear sign voids it.
  function automatic logic edge_crosses(cross_t sx, cross_t sy, cross_t ex, cross_t ey,
                                        cross_t ux, cross_t uy, cross_t vx, cross_t vy);
    side_t o1, o2, o3, o4;
    o1 = side_of(sx, sy, ex, ey, ux, uy);
    o2 = side_of(sx, sy, ex, ey, vx, vy);
    o3 = side_of(ux, uy, vx, vy, sx, sy);
    o4 = side_of(ux, uy, vx, vy, ex, ey);
    if (o1 == SIDE_ON || o2 == SIDE_ON || o3 == SIDE_ON || o4 == SIDE_ON) return 1'b0;
    return (o1 != o2) && (o3 != o4);
  endfunction

  // Advance the chain by one vertex; returns 1 when this vertex owes a verdict.
  function automatic logic chain_step(input vertex_beat_t b, output logic verdict);
    cross_t vx, vy;
    vx = widen(b.vx);
    vy = widen(b.vy);
    if (b.first) begin
      chain_open    = 1'b0;
      chain_crossed = 1'b0;
    end
    // The edge closed here is tested against the diagonal carried by this beat.
    if (chain_open && edge_crosses(widen(b.sx), widen(b.sy), widen(b.ex), widen(b.ey),
                                   chain_px, chain_py, vx, vy)) begin
      chain_crossed = 1'b1;
    end
    chain_px   = vx;
    chain_py   = vy;
    chain_open = 1'b1;
    verdict    = !chain_crossed;
    if (b.last) begin
      chain_open    = 1'b0;
      chain_crossed = 1'b0;
    end
    return b.last;
  endfunction

  task automatic flag_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge. Pop before push, since a
  // beat taken at this edge cannot have produced a verdict at the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    vertex_beat_t seen;
    logic         verdict;
    logic         want;
    if (rst_n) begin
      if (verdict_ch.valid && verdict_ch.ready) begin
        if (verdict_q.size() == 0) begin
          flag_mismatch($sformatf("verdict %b with none pending", verdict_ch.is_diagonal));
        end else begin
          want = verdict_q.pop_front();
          if (verdict_ch.is_diagonal !== want) begin
            flag_mismatch($sformatf("is_diagonal %b, expected %b",
                                    verdict_ch.is_diagonal, want));
          end
        end
      end
      if (vtx_ch.valid && vtx_ch.ready) begin
        seen.sx    = vtx_ch.diag_start_x;
        seen.sy    = vtx_ch.diag_start_y;
        seen.ex    = vtx_ch.diag_end_x;
        seen.ey    = vtx_ch.diag_end_y;
        seen.vx    = vtx_ch.vertex_x;
        seen.vy    = vtx_ch.vertex_y;
        seen.first = vtx_ch.first_vertex;
        seen.last  = vtx_ch.last_vertex;
        // Run the predictor on every beat so the chain state stays in step.
        if (chain_step(seen, verdict)) begin
          verdict_q.insert(verdict_q.size(), row_typed ? row_verdict : verdict);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure at the falling edge, plus a long hold-off
  // on request, counted here so the sender keeps offering beats meanwhile.
  // ---------------------------------------------------------------------------
  initial begin
    verdict_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        verdict_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        hold_left   = HOLD_CYCLES;
        verdict_ch.ready <= 1'b0;
      end else begin
        verdict_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run once nothing has moved for too long.
  // ---------------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (vtx_ch.valid && vtx_ch.ready) ||
          (verdict_ch.valid && verdict_ch.ready) || (cfg_psel && cfg_penable)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Every task is entered and left at a falling edge.
  // ---------------------------------------------------------------------------

  // Offer one vertex beat after a random gap and hold it until it is taken.
  task automatic send_vertex(vertex_beat_t b, verdict_src_t src, logic verdict);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      vtx_ch.valid <= 1'b0;
      @(negedge clk);
    end
    vtx_ch.diag_start_x <= b.sx;
    vtx_ch.diag_start_y <= b.sy;
    vtx_ch.diag_end_x   <= b.ex;
    vtx_ch.diag_end_y   <= b.ey;
    vtx_ch.vertex_x     <= b.vx;
    vtx_ch.vertex_y     <= b.vy;
    vtx_ch.first_vertex <= b.first;
    vtx_ch.last_vertex  <= b.last;
    row_typed           <= (src == CHK_TABLE);
    row_verdict         <= verdict;
    vtx_ch.valid        <= 1'b1;
    do @(posedge clk); while (!vtx_ch.ready);
    beats_sent++;
    @(negedge clk);
  endtask

  // Drop valid, wait for every owed verdict, then let the pipeline run dry:
  // chains left open may still be in flight after the last verdict.
  task automatic wait_drained();
    vtx_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write the tolerance, then read it back; only the low TOL_W bits stick.
  task automatic write_tolerance(logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] rd;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= TOL_ADDR;
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    tol_shadow = value[TOL_W-1:0];
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd !== {{(CFG_DATA_W - TOL_W){1'b0}}, value[TOL_W-1:0]}) begin
      flag_mismatch($sformatf("tolerance read back %h after writing %h", rd, value));
    end
  endtask

  task automatic add_row(input int sx, sy, ex, ey, vx, vy,
                         input logic first, last, input verdict_src_t src,
                         input logic verdict);
    directed_row_t r;
    r.beat    = '{sx: sx, sy: sy, ex: ex, ey: ey, vx: vx, vy: vy, first: first, last: last};
    r.src     = src;
    r.verdict = verdict;
    directed_rows.insert(directed_rows.size(), r);
  endtask

  function automatic logic [FIELD_W-1:0] pick_coord(coord_mode_t mode);
    case (mode)
      SPAN_FULL:  return $urandom;
      SPAN_UNITS: return FIELD_W'($urandom_range(0, 16 * UNIT)) - FIELD_W'(8 * UNIT);
      SPAN_LSB:   return FIELD_W'($urandom_range(0, 64)) - FIELD_W'(32);
      default: begin
        case ($urandom_range(0, 5))
          0:       return C_MIN;
          1:       return C_MAX;
          2:       return '0;
          3:       return '1;
          4:       return FIELD_W'(1);
          default: return FIELD_W'(UNIT);
        endcase
      end
    endcase
  endfunction

  // One random chain: mostly well formed, sometimes with scattered flags.
  // Some vertices sit exactly on the diagonal's line to hit the collinear case.
  task automatic send_chain();
    vertex_beat_t b;
    coord_mode_t  mode;
    int           len;
    int           k;
    logic         well_formed;
    mode        = coord_mode_t'($urandom_range(0, 3));
    len         = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
    well_formed = ($urandom_range(0, 9) < 8);
    b.sx = pick_coord(mode);
    b.sy = pick_coord(mode);
    b.ex = pick_coord(mode);
    b.ey = pick_coord(mode);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        b.sx = pick_coord(mode);
        b.sy = pick_coord(mode);
        b.ex = pick_coord(mode);
        b.ey = pick_coord(mode);
      end
      if ($urandom_range(0, 2) == 0) begin
        k = (mode == SPAN_FULL) ? $urandom_range(0, 1) : $urandom_range(0, 3) - 1;
        b.vx = FIELD_W'(int'(b.sx) + k * (int'(b.ex) - int'(b.sx)));
        b.vy = FIELD_W'(int'(b.sy) + k * (int'(b.ey) - int'(b.sy)));
      end else begin
        b.vx = pick_coord(mode);
        b.vy = pick_coord(mode);
      end
      if (well_formed) begin
        b.first = (i == 0);
        b.last  = (i == len - 1);
      end else begin
        b.first = ($urandom_range(0, 4) == 0);
        b.last  = ($urandom_range(0, 4) == 0);
      end
      send_vertex(b, CHK_MODEL, 1'b0);
    end
  endtask

  // One tolerance setting: write it while idle, then stream random chains.
  // Optionally pause for a full drain or ask the receiver for a long hold-off.
  task automatic run_segment(logic [CFG_DATA_W-1:0] tol, logic pause_midway,
                             logic hold_midway);
    int   target;
    logic midway_done;
    wait_drained();
    write_tolerance(tol);
    target      = beats_sent + SEG_BEATS;
    midway_done = 1'b0;
    while (beats_sent < target) begin
      if (!midway_done && beats_sent >= target - SEG_BEATS / 2) begin
        midway_done = 1'b1;
        if (pause_midway) wait_drained();
        if (hold_midway) hold_asked++;
      end
      send_chain();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n               = 1'b0;
    vtx_ch.valid        = 1'b0;
    vtx_ch.diag_start_x = '0;
    vtx_ch.diag_start_y = '0;
    vtx_ch.diag_end_x   = '0;
    vtx_ch.diag_end_y   = '0;
    vtx_ch.vertex_x     = '0;
    vtx_ch.vertex_y     = '0;
    vtx_ch.first_vertex = 1'b0;
    vtx_ch.last_vertex  = 1'b0;
    row_typed           = 1'b0;
    row_verdict         = 1'b0;
    cfg_psel            = 1'b0;
    cfg_penable         = 1'b0;
    cfg_pwrite          = 1'b0;
    cfg_paddr           = '0;
    cfg_pwdata          = '0;

    // Directed rows, run at the reset tolerance. Columns: diagonal start and
    // end, vertex, first, last, where the verdict comes from, typed verdict.
    // Lone vertex at the coordinate extremes: no edge, so it is a diagonal.
    add_row(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, 1, 1, CHK_TABLE, 1);
    // Full-scale edge straight across a full-scale diagonal.
    add_row(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, 1, 0, CHK_MODEL, 0);
    add_row(C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, 0, 1, CHK_TABLE, 0);
    // Diagonal shrunk to a point: every sign against it is zero.
    add_row(2*UNIT, 2*UNIT, 2*UNIT, 2*UNIT, 0, 4*UNIT, 1, 0, CHK_MODEL, 0);
    add_row(2*UNIT, 2*UNIT, 2*UNIT, 2*UNIT, 4*UNIT, 0, 0, 1, CHK_TABLE, 1);
    // Plain crossing.
    add_row(0, 0, 4*UNIT, 4*UNIT, 0, 4*UNIT, 1, 0, CHK_MODEL, 0);
    add_row(0, 0, 4*UNIT, 4*UNIT, 4*UNIT, 0, 0, 1, CHK_TABLE, 0);
    // Edge touching the diagonal at a vertex is collinear, not a crossing.
    add_row(0, 0, 4*UNIT, 4*UNIT, 2*UNIT, 2*UNIT, 1, 0, CHK_MODEL, 0);
    add_row(0, 0, 4*UNIT, 4*UNIT, 4*UNIT, 0, 0, 1, CHK_TABLE, 1);
    // Edge wholly to one side.
    add_row(0, 0, 4*UNIT, 4*UNIT, UNIT, 0, 1, 0, CHK_MODEL, 0);
    add_row(0, 0, 4*UNIT, 4*UNIT, 4*UNIT, 0, 0, 1, CHK_MODEL, 0);
    // Chain opened without a first flag right after a last vertex.
    add_row(0, 0, 4*UNIT, 4*UNIT, 0, 4*UNIT, 0, 0, CHK_MODEL, 0);
    add_row(0, 0, 4*UNIT, 4*UNIT, 4*UNIT, 0, 0, 1, CHK_MODEL, 0);
    // First flag in mid chain drops the crossing edge it would have closed.
    add_row(0, 0, 4*UNIT, 4*UNIT, 0, 4*UNIT, 1, 0, CHK_MODEL, 0);
    add_row(0, 0, 4*UNIT, 4*UNIT, 4*UNIT, 0, 1, 0, CHK_MODEL, 0);
    add_row(0, 0, 4*UNIT, 4*UNIT, 6*UNIT, 4*UNIT, 0, 1, CHK_MODEL, 0);
    // The edge uses the diagonal of the beat that closes it, not the opener's.
    add_row(10*UNIT, 10*UNIT, 11*UNIT, 11*UNIT, 0, 4*UNIT, 1, 0, CHK_MODEL, 0);
    add_row(0, 0, 4*UNIT, 4*UNIT, 4*UNIT, 0, 0, 1, CHK_MODEL, 0);
    // Only the untested closing edge would cross.
    add_row(0, 0, 4*UNIT, 4*UNIT, 0, 4*UNIT, 1, 0, CHK_MODEL, 0);
    add_row(0, 0, 4*UNIT, 4*UNIT, -4*UNIT, 0, 0, 0, CHK_MODEL, 0);
    add_row(0, 0, 4*UNIT, 4*UNIT, -4*UNIT, -8*UNIT, 0, 0, CHK_MODEL, 0);
    add_row(0, 0, 4*UNIT, 4*UNIT, 4*UNIT, 0, 0, 1, CHK_MODEL, 0);
    // Crossing of one-LSB segments falls inside the tolerance band.
    add_row(0, 0, 1, 1, 0, 1, 1, 0, CHK_MODEL, 0);
    add_row(0, 0, 1, 1, 1, 0, 0, 1, CHK_TABLE, 1);
    // Leave a chain open with no first flag; the random part takes over.
    add_row(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, 0, 0, CHK_MODEL, 0);

    // Sender idles rarely, receiver often.
    send_idle_pct = 16;
    recv_idle_pct = 87;

    // Hold reset, then release it at a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_vertex(directed_rows[i].beat, directed_rows[i].src, directed_rows[i].verdict);
    end

    // Zero tolerance, then the widest one with a full drain midway.
    run_segment('0, 1'b0, 1'b0);
    run_segment('1, 1'b1, 1'b0);

    // Sender idles often, receiver rarely.
    send_idle_pct = 87;
    recv_idle_pct = 16;
    run_segment({$urandom, $urandom}, 1'b0, 1'b0);
    run_segment(CFG_DATA_W'(1), 1'b0, 1'b0);

    // No idling; the receiver holds off for a long stretch midway.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_segment(CFG_DATA_W'($urandom_range(0, 1 << 20)), 1'b0, 1'b1);
    run_segment(CFG_DATA_W'(dec_pkg::TOL_RESET), 1'b0, 1'b0);

    wait_drained();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
